// ===== design/pssr_pkg.sv =====
// Shared types, command codes and constants for the peer slot select and reclaim block.
`default_nettype none

package pssr_pkg;

  // Default number of table slots; the top level hands it down as a parameter.
  localparam int TableSlotsDef = 16;

  // Depth of the command queue between the front and the back.
  localparam int QueueDepth = 2;

  // Command codes on the input item.
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_COUNT  = 2'd2;

  // Outcome codes on the result item.
  localparam logic [2:0] OUT_REJECT = 3'd0;
  localparam logic [2:0] OUT_HIT    = 3'd1;
  localparam logic [2:0] OUT_NEW    = 3'd2;
  localparam logic [2:0] OUT_NONE   = 3'd3;
  localparam logic [2:0] OUT_WRITE  = 3'd4;

  localparam logic [4:0]  PEER_LIMIT           = 5'd16;
  localparam logic [4:0]  SLOTS_RESET          = 5'd16;
  localparam logic [15:0] RECLAIM_STATUS_LIMIT = 16'h0030;
  localparam logic [16:0] SCORE_CEILING        = 17'h10000;

  typedef struct packed {
    logic [1:0]  command;
    logic [47:0] peer_mac;
    logic [3:0]  entry_index;
    logic [15:0] entry_status;
    logic [15:0] entry_pin;
    logic [15:0] entry_score;
    logic [4:0]  peer_total;
  } in_item_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic [3:0] chosen_slot;
  } out_item_t;

  // Operation decided by the front.
  typedef enum logic [2:0] {
    OP_LOOKUP,
    OP_REJECT,
    OP_WRITE,
    OP_COUNT,
    OP_NOP
  } op_e;

  // Classified command as it waits in the queue.
  typedef struct packed {
    op_e         op;
    logic [47:0] mac;
    logic [3:0]  index;
    logic [15:0] status;
    logic [15:0] pin;
    logic [15:0] score;
    logic [4:0]  peers;
  } cmd_t;

  // One table entry as stored in the RAM.
  typedef struct packed {
    logic [15:0] status;
    logic [47:0] mac;
    logic [15:0] pin;
    logic [15:0] score;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RECLAIM
  } state_e;

endpackage

`default_nettype wire

// ===== design/pssr_ram.sv =====
// Generic single write port RAM with one registered read port.
`default_nettype none

module pssr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/pssr_front.sv =====
// Front part: accepts input items, classifies them and queues them for the back part.
`default_nettype none

module pssr_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output      logic              full,
  input  wire pssr_pkg::in_item_t in_item_i,
  output      logic              cmd_valid_o,
  output      pssr_pkg::cmd_t    cmd_o,
  input  wire logic              cmd_pop_i
);

  localparam int PtrW = $clog2(pssr_pkg::QueueDepth);
  localparam int CntW = $clog2(pssr_pkg::QueueDepth + 1);

  pssr_pkg::cmd_t  entries_q [pssr_pkg::QueueDepth];
  pssr_pkg::cmd_t  cls;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  // Classify: a lookup of a group address is rejected right here.
  always_comb begin
    cls.mac    = in_item_i.peer_mac;
    cls.index  = in_item_i.entry_index;
    cls.status = in_item_i.entry_status;
    cls.pin    = in_item_i.entry_pin;
    cls.score  = in_item_i.entry_score;
    cls.peers  = (in_item_i.peer_total > pssr_pkg::PEER_LIMIT) ? pssr_pkg::PEER_LIMIT
                                                               : in_item_i.peer_total;
    case (in_item_i.command)
      pssr_pkg::CMD_LOOKUP: begin
        cls.op = in_item_i.peer_mac[0] ? pssr_pkg::OP_REJECT : pssr_pkg::OP_LOOKUP;
      end
      pssr_pkg::CMD_WRITE: cls.op = pssr_pkg::OP_WRITE;
      pssr_pkg::CMD_COUNT: cls.op = pssr_pkg::OP_COUNT;
      default:             cls.op = pssr_pkg::OP_NOP;
    endcase
  end

  assign full        = (cnt_q == CntW'(pssr_pkg::QueueDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = entries_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == pssr_pkg::QueueDepth - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == pssr_pkg::QueueDepth - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

// ===== design/pssr_back.sv =====
// Back part: executes queued commands against the peer table and holds the result.
`default_nettype none

module pssr_back #(
  parameter int TableSlots = pssr_pkg::TableSlotsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [4:0]         slots_in_use_i,
  input  wire logic               cmd_valid_i,
  input  wire pssr_pkg::cmd_t     cmd_i,
  output      logic               cmd_pop_o,
  input  wire logic               res_pop_i,
  output      logic               res_valid_o,
  output      pssr_pkg::out_item_t res_o
);

  localparam int SlotW = $clog2(TableSlots);
  localparam int LimW  = $clog2(TableSlots + 1);

  function automatic logic [3:0] slot4(input logic [LimW-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[3:0];
  endfunction

  pssr_pkg::state_e    st_q, st_d;
  pssr_pkg::out_item_t res_q, res_d;
  logic                res_valid_q, res_valid_d;
  logic [TableSlots-1:0] valid_q, valid_d;
  logic [4:0]          peers_q, peers_d, seen_q, seen_d, seen_inc;
  logic [47:0]         mac_q, mac_d;
  logic [LimW-1:0]     cur_q, cur_d, cur_inc, empty_q, empty_d, empty_nx;
  logic [LimW-1:0]     best_slot_q, best_slot_d, best_slot_nx, limit;
  logic [16:0]         best_q, best_d, best_nx;
  logic                take, walk_go, occupied, mac_hit, walk_stop, walk_last, cand_ok;
  logic                we;
  logic [SlotW-1:0]    raddr, waddr;
  logic [31:0]         idx_wide;
  logic [$bits(pssr_pkg::entry_t)-1:0] rdata;
  pssr_pkg::entry_t    wentry, ent;

  assign limit = (32'(slots_in_use_i) > TableSlots) ? LimW'(TableSlots)
                                                    : LimW'(slots_in_use_i);

  assign take      = (st_q == pssr_pkg::ST_IDLE) && cmd_valid_i && !res_valid_q;
  assign cmd_pop_o = take;
  assign walk_go   = (peers_q > 5'd1) && (limit > LimW'(1));

  assign idx_wide = 32'(cmd_i.index);
  assign waddr    = idx_wide[SlotW-1:0];
  assign wentry   = '{status: cmd_i.status, mac: cmd_i.mac, pin: cmd_i.pin,
                      score: cmd_i.score};

  pssr_ram #(
    .Width($bits(pssr_pkg::entry_t)),
    .Depth(TableSlots)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wentry),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Entries never written read as empty.
  assign ent = valid_q[cur_q[SlotW-1:0]] ? pssr_pkg::entry_t'(rdata) : '0;

  assign occupied     = (ent.status != '0);
  assign mac_hit      = occupied && (ent.mac == mac_q);
  assign seen_inc     = seen_q + 5'd1;
  assign walk_stop    = occupied && !mac_hit && (seen_inc >= peers_q);
  assign empty_nx     = ((empty_q == '0) && !occupied) ? cur_q : empty_q;
  assign cur_inc      = cur_q + LimW'(1);
  assign walk_last    = (cur_inc >= limit);
  assign cand_ok      = (ent.status < pssr_pkg::RECLAIM_STATUS_LIMIT) && (ent.pin == '0) &&
                        ({1'b0, ent.score} < best_q);
  assign best_nx      = cand_ok ? {1'b0, ent.score} : best_q;
  assign best_slot_nx = cand_ok ? cur_q : best_slot_q;

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      pssr_pkg::ST_IDLE: begin
        if (take && (cmd_i.op == pssr_pkg::OP_LOOKUP) && walk_go) begin
          st_d = pssr_pkg::ST_WALK;
        end
      end
      pssr_pkg::ST_WALK: begin
        if (mac_hit || walk_stop) begin
          st_d = pssr_pkg::ST_IDLE;
        end else if (walk_last) begin
          st_d = (empty_nx != '0) ? pssr_pkg::ST_IDLE : pssr_pkg::ST_RECLAIM;
        end
      end
      pssr_pkg::ST_RECLAIM: begin
        if (walk_last) begin
          st_d = pssr_pkg::ST_IDLE;
        end
      end
      default: st_d = pssr_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    res_valid_d = res_valid_q && !res_pop_i;
    res_d       = res_q;
    valid_d     = valid_q;
    peers_d     = peers_q;
    seen_d      = seen_q;
    mac_d       = mac_q;
    cur_d       = cur_q;
    empty_d     = empty_q;
    best_d      = best_q;
    best_slot_d = best_slot_q;
    we          = 1'b0;
    raddr       = cur_inc[SlotW-1:0];
    case (st_q)
      pssr_pkg::ST_IDLE: begin
        if (take) begin
          res_valid_d = 1'b1;
          res_d       = '{outcome: pssr_pkg::OUT_WRITE, chosen_slot: 4'd0};
          case (cmd_i.op)
            pssr_pkg::OP_REJECT: res_d.outcome = pssr_pkg::OUT_REJECT;
            pssr_pkg::OP_WRITE: begin
              if (idx_wide < TableSlots) begin
                we             = 1'b1;
                valid_d[waddr] = 1'b1;
              end
            end
            pssr_pkg::OP_COUNT: peers_d = cmd_i.peers;
            pssr_pkg::OP_LOOKUP: begin
              mac_d = cmd_i.mac;
              if (walk_go) begin
                res_valid_d = 1'b0;
                cur_d       = LimW'(1);
                seen_d      = '0;
                empty_d     = '0;
                raddr       = SlotW'(1);
              end else if (limit > LimW'(1)) begin
                res_d = '{outcome: pssr_pkg::OUT_NEW, chosen_slot: 4'd1};
              end else begin
                res_d.outcome = pssr_pkg::OUT_NONE;
              end
            end
            default: ;
          endcase
        end
      end
      pssr_pkg::ST_WALK: begin
        if (mac_hit) begin
          res_valid_d = 1'b1;
          res_d       = '{outcome: pssr_pkg::OUT_HIT, chosen_slot: slot4(cur_q)};
        end else if (walk_stop) begin
          res_valid_d = 1'b1;
          res_d       = '{outcome: pssr_pkg::OUT_NEW,
                          chosen_slot: slot4((empty_nx != '0) ? empty_nx : cur_q)};
        end else begin
          seen_d  = occupied ? seen_inc : seen_q;
          empty_d = empty_nx;
          if (walk_last) begin
            if (empty_nx != '0) begin
              res_valid_d = 1'b1;
              res_d       = '{outcome: pssr_pkg::OUT_NEW, chosen_slot: slot4(empty_nx)};
            end else begin
              cur_d       = LimW'(1);
              best_d      = pssr_pkg::SCORE_CEILING;
              best_slot_d = '0;
              raddr       = SlotW'(1);
            end
          end else begin
            cur_d = cur_inc;
          end
        end
      end
      pssr_pkg::ST_RECLAIM: begin
        best_d      = best_nx;
        best_slot_d = best_slot_nx;
        if (walk_last) begin
          res_valid_d = 1'b1;
          if (best_slot_nx == '0) begin
            res_d = '{outcome: pssr_pkg::OUT_NONE, chosen_slot: 4'd0};
          end else begin
            res_d = '{outcome: pssr_pkg::OUT_NEW, chosen_slot: slot4(best_slot_nx)};
          end
        end else begin
          cur_d = cur_inc;
        end
      end
      default: ;
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= pssr_pkg::ST_IDLE;
      res_valid_q <= 1'b0;
      valid_q     <= '0;
      peers_q     <= '0;
    end else begin
      st_q        <= st_d;
      res_valid_q <= res_valid_d;
      valid_q     <= valid_d;
      peers_q     <= peers_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q       <= res_d;
    seen_q      <= seen_d;
    mac_q       <= mac_d;
    cur_q       <= cur_d;
    empty_q     <= empty_d;
    best_q      <= best_d;
    best_slot_q <= best_slot_d;
  end

`ifndef NO_ASSERTIONS
  // The walk and the reclaim scan never look past the slots in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != pssr_pkg::ST_IDLE) |-> (cur_q < limit))
    else $error("scan slot beyond slots in use");

  // The walk stops before it has seen as many peers as are registered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == pssr_pkg::ST_WALK) |-> (seen_q < peers_q))
    else $error("walk ran past registered peer count");

  // A new command is only taken once the previous result has gone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_pop_i) |=> (res_valid_q && $stable(res_q)))
    else $error("pending result overwritten");

  // A hit or a new slot never names slot zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.outcome == pssr_pkg::OUT_HIT ||
                     res_q.outcome == pssr_pkg::OUT_NEW)) |-> (res_q.chosen_slot != 4'd0)
                     || (TableSlots > 16))
    else $error("slot zero chosen");
`endif

endmodule

`default_nettype wire

// ===== design/peer_slot_select_reclaim_core.sv =====
// Top level of the peer slot select and reclaim block.
`default_nettype none

// Peer table with slot selection and reclaim. Items enter through a queue-style
// port (push/full) and results leave through another (empty/pop); both sides
// stall on their own, with a two-entry command queue between the front, which
// decodes items and rejects group addresses, and the back, which owns the
// table. For write, count and rejected lookups, the item passes through the
// command queue and the back's result register before it can be popped.
// A lookup reads the table one slot per cycle through a single read port, first
// in a match walk and then, if the walk ends with no free slot found, in a
// reclaim scan; each of the two covers at most slots 1 to (slots in use - 1).
// The back takes the next item only once the previous result has been popped.
// The table is cleared at reset by per-slot valid flags, so there is no
// clearing pass and the block takes items right after reset. The slots_in_use
// register is written on the configuration channel, which is always ready; it
// must only be written while no item is in flight. A lookup never binds the
// address into the table: software follows up with a write item for the
// chosen slot.
module peer_slot_select_reclaim_core #(
  parameter int TableSlots = pssr_pkg::TableSlotsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output      logic                full,
  input  wire pssr_pkg::in_item_t  in_item_i,
  output      logic                empty,
  input  wire logic                pop,
  output      pssr_pkg::out_item_t out_item_o,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [4:0]          cfg_data_i
);

  logic           cmd_valid, cmd_pop, res_valid;
  pssr_pkg::cmd_t cmd;
  logic [4:0]     slots_in_use_q;

  // The configuration register is taken on any valid cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_in_use_q <= pssr_pkg::SLOTS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      slots_in_use_q <= cfg_data_i;
    end
  end

  pssr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  pssr_back #(
    .TableSlots(TableSlots)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .slots_in_use_i(slots_in_use_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .res_pop_i     (pop && res_valid),
    .res_valid_o   (res_valid),
    .res_o         (out_item_o)
  );

  // The oldest result sits in the back's output register until popped.
  assign empty = !res_valid;

endmodule

`default_nettype wire
